/* rtl/core/srsw_pkg.sv */
// Shared types and constants of the selective-repeat sender window.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none

package srsw_pkg;

  localparam int SLOTS       = 20;
  localparam int WINDOW      = 10;
  localparam int MAX_PAYLOAD = 512;
  localparam int SEQ_MODULUS = 25601;
  localparam int SPAN        = (WINDOW < SLOTS) ? WINDOW : SLOTS;

  localparam int SLOT_W = 5;
  localparam int SEQ_W  = 15;
  localparam int LEN_W  = 10;
  localparam int ACK_W  = 16;
  localparam int TMO_W  = 16;
  localparam int TICK_W = 32;
  localparam int ADV_W  = 4;
  localparam int CNT_W  = $clog2(SPAN + 1);
  localparam int WALK_W = $clog2(WINDOW + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_START   = 2'd0;
  localparam logic [1:0] REG_PEER    = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_TX_NEW      = 3'd0,
    ST_RETX        = 3'd1,
    ST_ACK_IGNORED = 3'd2,
    ST_ACK_OK      = 3'd3,
    ST_REFUSED     = 3'd4,
    ST_NOTHING_DUE = 3'd5
  } status_e;

  typedef struct packed {
    kind_e              kind;
    logic [LEN_W-1:0]   payload_length;
    logic [SLOT_W-1:0]  ack_slot;
    logic [ACK_W-1:0]   acked_through;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [SEQ_W-1:0]   sequence_res;
    logic [LEN_W-1:0]   length;
    logic               ack_flag;
    logic [ADV_W-1:0]   advanced;
    logic               all_acked;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/srsw_req_if.sv */
// Request channel of the sender window: valid/ready plus one input request.
// Depends on srsw_pkg for the request type.
`default_nettype none

interface srsw_req_if import srsw_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/srsw_res_if.sv */
// Result channel of the sender window: valid/ready plus one result.
// Depends on srsw_pkg for the result type.
`default_nettype none

interface srsw_res_if import srsw_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/selective_repeat_sender_window.sv */
// Sender-side window bookkeeping for selective-repeat ARQ over a ring of slots.
// Depends on srsw_pkg, srsw_req_if and srsw_res_if.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_i     in         valid/ready            kind, payload_length, ack_slot, acked_through
// res_o     out        valid/ready            status, slot, sequence_res, length, ...
// apb       in         psel/penable/pwrite    paddr, pwdata (prdata on reads)
//
// A request is taken from the idle state, then handled by a small sequencer that walks
// the slot ring one slot per cycle unless a stalled result holds it. A send and an ack
// off the base slot each give one result; an ack on the base slot also releases the
// acked slots from the base, and a tick scans the 10-slot window slot by slot.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds the sequencer in place; up to one further result is
// held in a pending register so that the last flag can be set correctly.
module selective_repeat_sender_window import srsw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  srsw_req_if.sink               req_i,
  srsw_res_if.source             res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_ACK,
    S_WALK,
    S_SCAN
  } state_e;

  // Configuration registers.
  logic [SEQ_W-1:0]  start_q;
  logic [ACK_W-1:0]  peer_ack_q;
  logic [TMO_W-1:0]  timeout_q;

  // Window state.
  logic [SLOTS-1:0]  slot_sent_q;
  logic [SLOTS-1:0]  slot_acked_q;
  logic [TICK_W-1:0] tick_q;
  logic [SLOT_W-1:0] base_q;
  logic [SLOT_W-1:0] next_q;
  logic [SEQ_W-1:0]  next_seq_q;
  logic              ack_pending_q;

  // Per-slot storage, only read for slots that were sent.
  logic [SEQ_W-1:0]  seq_mem  [SLOTS];
  logic [LEN_W-1:0]  len_mem  [SLOTS];
  logic [TICK_W-1:0] dl_mem   [SLOTS];

  // Sequencer.
  state_e            state_q;
  req_t              req_q;
  logic [SLOT_W-1:0] ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WALK_W-1:0] adv_q;
  logic              pend_valid_q;
  res_t              pend_q;
  logic              out_valid_q;
  res_t              out_q;

  logic              cfg_wr;
  logic              out_free;
  logic [TMO_W-1:0]  eff_timeout;
  logic [SLOT_W:0]   outstanding;
  logic              send_refused;
  logic              send_take;
  logic [SEQ_W:0]    seq_sum;
  logic [SEQ_W-1:0]  seq_next;
  logic [SEQ_W:0]    start_wrap;
  logic              ack_ok;
  logic [TICK_W-1:0] age;
  logic              scan_hit;
  logic              scan_take;
  logic              walk_more;
  logic              all_acked;
  logic [TICK_W-1:0] new_deadline;
  res_t              send_res;
  res_t              ack_res;
  res_t              scan_res;
  res_t              pend_last;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    slot_inc = (p == SLOT_W'(SLOTS - 1)) ? '0 : p + SLOT_W'(1);
  endfunction

  function automatic res_t res_plain(input status_e st, input logic [SLOT_W-1:0] sl);
    res_t r;
    r        = '0;
    r.status = st;
    r.slot   = sl;
    r.last   = 1'b1;
    res_plain = r;
  endfunction

  // The configuration port is always ready and writes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_START:   prdata = DATA_W'(start_q);
      REG_PEER:    prdata = DATA_W'(peer_ack_q);
      REG_TIMEOUT: prdata = DATA_W'(timeout_q);
      default:     prdata = '0;
    endcase
  end

  // A start sequence is below twice the modulus, so one compare and subtract
  // reduces it.
  always_comb begin
    start_wrap = {1'b0, pwdata[SEQ_W-1:0]};
    if (start_wrap >= (SEQ_W + 1)'(SEQ_MODULUS)) begin
      start_wrap = start_wrap - (SEQ_W + 1)'(SEQ_MODULUS);
    end
  end

  assign out_free     = !out_valid_q || res_o.ready;
  assign eff_timeout  = (timeout_q == '0) ? TMO_W'(1) : timeout_q;
  assign new_deadline = tick_q + TICK_W'(eff_timeout);

  // Send: how many slots sit between base and next decides whether the window
  // is full; the sequence number then advances by the length, modulo the space.
  assign outstanding = (next_q >= base_q)
                       ? ({1'b0, next_q} - {1'b0, base_q})
                       : ({1'b0, next_q} + (SLOT_W + 1)'(SLOTS) - {1'b0, base_q});
  assign send_refused = (req_q.payload_length == '0)
                     || (req_q.payload_length > LEN_W'(MAX_PAYLOAD))
                     || (outstanding >= (SLOT_W + 1)'(WINDOW))
                     || slot_sent_q[next_q];
  assign send_take = (state_q == S_SEND) && out_free && !send_refused;
  assign seq_sum   = {1'b0, next_seq_q} + (SEQ_W + 1)'(req_q.payload_length);
  assign seq_next  = (seq_sum >= (SEQ_W + 1)'(SEQ_MODULUS))
                     ? SEQ_W'(seq_sum - (SEQ_W + 1)'(SEQ_MODULUS))
                     : SEQ_W'(seq_sum);

  always_comb begin
    send_res              = res_plain(ST_TX_NEW, next_q);
    send_res.sequence_res = next_seq_q;
    send_res.length       = req_q.payload_length;
    send_res.ack_flag     = ack_pending_q;
    if (send_refused) begin
      send_res = res_plain(ST_REFUSED, '0);
    end
  end

  // Ack: a slot beyond the ring or never sent is ignored.
  assign ack_ok = (req_q.ack_slot < SLOT_W'(SLOTS)) && slot_sent_q[req_q.ack_slot];

  // Walk: release the base slot while it is acked, up to a window's worth.
  assign walk_more = (adv_q < WALK_W'(WINDOW)) && slot_acked_q[base_q];
  assign all_acked = (adv_q != '0) && (base_q == next_q) && !slot_sent_q[next_q];

  always_comb begin
    ack_res           = res_plain(ST_ACK_OK, req_q.ack_slot);
    ack_res.advanced  = ADV_W'(adv_q);
    ack_res.all_acked = all_acked;
  end

  // Scan: wrap-safe deadline test, expired when tick minus deadline is
  // non-negative as a signed 32-bit value.
  assign age       = tick_q - dl_mem[ptr_q];
  assign scan_hit  = slot_sent_q[ptr_q] && !slot_acked_q[ptr_q] && !age[TICK_W-1];
  assign scan_take = (state_q == S_SCAN) && (cnt_q != CNT_W'(SPAN)) && scan_hit
                     && (!pend_valid_q || out_free);

  always_comb begin
    scan_res              = '0;
    scan_res.status       = ST_RETX;
    scan_res.slot         = ptr_q;
    scan_res.sequence_res = seq_mem[ptr_q];
    scan_res.length       = len_mem[ptr_q];
    scan_res.ack_flag     = ack_pending_q;
  end

  // The held retransmit as it leaves at the end of the scan, marked as the last one.
  always_comb begin
    pend_last      = pend_q;
    pend_last.last = 1'b1;
  end

  // Per-slot storage writes: one address per cycle, send and scan never overlap.
  always_ff @(posedge clk_i) begin
    if (send_take) begin
      seq_mem[next_q] <= next_seq_q;
      len_mem[next_q] <= req_q.payload_length;
      dl_mem[next_q]  <= new_deadline;
    end else if (scan_take) begin
      dl_mem[ptr_q]   <= new_deadline;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= '0;
      peer_ack_q    <= '0;
      timeout_q     <= TMO_W'(500);
      slot_sent_q   <= '0;
      slot_acked_q  <= '0;
      tick_q        <= '0;
      base_q        <= '0;
      next_q        <= '0;
      next_seq_q    <= '0;
      ack_pending_q <= 1'b1;
      state_q       <= S_IDLE;
      req_q         <= '0;
      ptr_q         <= '0;
      cnt_q         <= '0;
      adv_q         <= '0;
      pend_valid_q  <= 1'b0;
      pend_q        <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // Configuration must be written only while the sequencer is idle; the block does not enforce it.
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_START: begin
            start_q    <= pwdata[SEQ_W-1:0];
            next_seq_q <= SEQ_W'(start_wrap);
          end
          REG_PEER:    peer_ack_q <= pwdata[ACK_W-1:0];
          REG_TIMEOUT: timeout_q  <= pwdata[TMO_W-1:0];
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q <= req_i.data;
            unique case (req_i.data.kind)
              KIND_SEND: state_q <= S_SEND;
              KIND_ACK:  state_q <= S_ACK;
              KIND_TICK: begin
                tick_q       <= tick_q + TICK_W'(1);
                ptr_q        <= base_q;
                cnt_q        <= '0;
                pend_valid_q <= 1'b0;
                state_q      <= S_SCAN;
              end
              KIND_NONE: state_q <= S_IDLE;
            endcase
          end
        end

        S_SEND: begin
          if (out_free) begin
            out_q       <= send_res;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (!send_refused) begin
              slot_sent_q[next_q]  <= 1'b1;
              slot_acked_q[next_q] <= 1'b0;
              ack_pending_q        <= 1'b0;
              next_q               <= slot_inc(next_q);
              next_seq_q           <= seq_next;
            end
          end
        end

        S_ACK: begin
          if (!ack_ok) begin
            if (out_free) begin
              out_q       <= res_plain(ST_ACK_IGNORED, req_q.ack_slot);
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else begin
            slot_acked_q[req_q.ack_slot] <= 1'b1;
            if (req_q.ack_slot == base_q) begin
              adv_q   <= '0;
              state_q <= S_WALK;
            end else if (out_free) begin
              out_q       <= res_plain(ST_ACK_OK, req_q.ack_slot);
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end
        end

        S_WALK: begin
          if (walk_more) begin
            slot_acked_q[base_q] <= 1'b0;
            slot_sent_q[base_q]  <= 1'b0;
            base_q               <= slot_inc(base_q);
            adv_q                <= adv_q + WALK_W'(1);
          end else if (out_free) begin
            out_q       <= ack_res;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (cnt_q == CNT_W'(SPAN)) begin
            // End of the window: the held retransmit, if any, is the last one.
            if (out_free) begin
              if (pend_valid_q) begin
                out_q <= pend_last;
              end else begin
                out_q <= res_plain(ST_NOTHING_DUE, '0);
              end
              out_valid_q  <= 1'b1;
              pend_valid_q <= 1'b0;
              state_q      <= S_IDLE;
            end
          end else if (scan_hit) begin
            // A new hit pushes the held one out, which therefore is not last.
            if (scan_take) begin
              if (pend_valid_q) begin
                out_q       <= pend_q;
                out_valid_q <= 1'b1;
              end
              pend_q        <= scan_res;
              pend_valid_q  <= 1'b1;
              ack_pending_q <= 1'b0;
              ptr_q         <= slot_inc(ptr_q);
              cnt_q         <= cnt_q + CNT_W'(1);
            end
          end else begin
            ptr_q <= slot_inc(ptr_q);
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // An acked slot is always a sent slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_acked_q & ~slot_sent_q) == '0)
    else $error("acked slot that was never sent");

  // The window never holds more than WINDOW outstanding slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding <= (SLOT_W + 1)'(WINDOW))
    else $error("window overfilled");

  // The base walk never releases more than one window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (adv_q <= WALK_W'(WINDOW)))
    else $error("base walk ran past the window");

  // An accepted tick advances the tick count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.data.kind == KIND_TICK) && !cfg_wr)
    |=> (tick_q == $past(tick_q) + TICK_W'(1)))
    else $error("tick count did not advance");

endmodule

`default_nettype wire
